[rtl/kama_pkg.sv]
// Shared types, constants and helpers of the adaptive moving average block.
package kama_pkg;

   localparam int SAMPLE_W = 32;
   localparam int WINDOW_W = 7;
   localparam int GUARD_W  = 16;
   localparam int AVG_W    = SAMPLE_W + GUARD_W;
   localparam int DIFF_W   = AVG_W + 1;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = DIFF_W + COEF_W;
   localparam int ER_W     = 17;
   localparam int DIGIT_W  = 4;
   localparam int N_DIGITS = COEF_W / DIGIT_W;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(10);
   localparam logic [COEF_W-1:0]   FAST_Q16     = COEF_W'(43693);
   localparam logic [COEF_W-1:0]   SLOW_Q16     = COEF_W'(4227);
   localparam logic [COEF_W-1:0]   FAST_SLOW_Q16 = FAST_Q16 - SLOW_Q16;
   localparam logic [ER_W-1:0]     ER_ONE       = ER_W'(65536);
   localparam int                  HALF_Q16     = 32768;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [AVG_W-1:0]    avg_type;
   typedef logic signed [DIFF_W-1:0]   diff_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic [COEF_W-1:0]          coef_type;
   typedef logic [ER_W-1:0]            ratio_type;

   // Magnitude of the difference of two samples; it always fits the sample width.
   function automatic logic [SAMPLE_W-1:0] abs_diff(input sample_type a, input sample_type b);
      logic signed [SAMPLE_W:0] d;
      logic signed [SAMPLE_W:0] n;
      d = (SAMPLE_W + 1)'(a) - (SAMPLE_W + 1)'(b);
      n = -d;
      return d[SAMPLE_W] ? n[SAMPLE_W-1:0] : d[SAMPLE_W-1:0];
   endfunction

endpackage

[rtl/kama_ram.sv]
// Generic single-write, single-read memory with a registered read.
module kama_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/kama_divider.sv]
// Restoring divider that forms the efficiency ratio one quotient bit per cycle.
module kama_divider #(
   parameter int VOL_W = 38
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [kama_pkg::SAMPLE_W-1:0]        dividend,
   input  logic [VOL_W-1:0]                     divisor,
   output logic                                 done,
   output logic [kama_pkg::ER_W-1:0]            quotient
);
   import kama_pkg::*;

   localparam int REM_W  = VOL_W + 1;
   localparam int STEP_W = $clog2(ER_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   ratio_type         quot_ff, quot_in;
   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  trial;
   logic              fits;

   // The first step takes the integer bit of the ratio, so it does not shift.
   always_comb begin
      shifted = (count_ff == STEP_W'(ER_W - 1)) ? rem_ff : (rem_ff << 1);
      trial   = shifted - REM_W'(divisor);
      fits    = shifted >= REM_W'(divisor);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = STEP_W'(ER_W - 1);
         rem_in   = REM_W'(dividend);
      end else if (busy_ff) begin
         rem_in  = fits ? trial : shifted;
         quot_in = {quot_ff[ER_W-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

   // A flat series has no volatility; its ratio is defined as zero.
   always_comb begin
      if (divisor == '0) begin
         quotient = '0;
      end else if (quot_ff > ER_ONE) begin
         quotient = ER_ONE;
      end else begin
         quotient = quot_ff;
      end
   end

   assign done = done_ff;

endmodule

[rtl/kama_multiplier.sv]
// Digit-serial signed product of the step toward the sample and the smoothing factor.
module kama_multiplier (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  kama_pkg::diff_type          multiplicand,
   input  kama_pkg::coef_type          coef,
   output logic                        done,
   output kama_pkg::prod_type          product
);
   import kama_pkg::*;

   localparam int CNT_W = (N_DIGITS > 1) ? $clog2(N_DIGITS) : 1;
   localparam int PART_W = DIFF_W + DIGIT_W + 1;
   localparam prod_type ROUND = PROD_W'(HALF_Q16);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   coef_type                      digits_ff, digits_in;
   prod_type                      acc_ff, acc_in;
   logic [DIGIT_W-1:0]            digit;
   logic signed [PART_W-1:0]      partial;
   logic                          last_step;

   // Horner form, most significant digit first; the rounding half joins the last digit.
   always_comb begin
      digit     = digits_ff[COEF_W-1 -: DIGIT_W];
      partial   = PART_W'(multiplicand) * PART_W'($signed({1'b0, digit}));
      last_step = (count_ff == '0);
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         count_in  = CNT_W'(N_DIGITS - 1);
         digits_in = coef;
         acc_in    = '0;
      end else if (busy_ff) begin
         acc_in    = (acc_ff <<< DIGIT_W) + PROD_W'(partial) + (last_step ? ROUND : '0);
         digits_in = digits_ff << DIGIT_W;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff  <= count_in;
      digits_ff <= digits_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[rtl/kaufman_adaptive_average_top.sv]
// Top level of the adaptive moving average: history rings, control sequence and output word.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_sample, req_series_start
//   rsp_     out        rsp_valid/rsp_stall  rsp_average
//   csr_     in         csr_valid/csr_ready  csr_window_length
//
// A word that completes a full window holds the block from acceptance until the next word
// can be taken, through the 17-step ratio divider and the 4-digit final product.
// Words before a full window return to idle after update; the seeding word goes to output.
// Reset clears the counters and volatility at once; the rings need no clearing pass.
// A stalled result word holds the block only when the next result is ready to leave.
module kaufman_adaptive_average_top #(
   parameter int MAX_PERIOD = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  kama_pkg::sample_type            req_sample,
   input  logic                            req_series_start,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output kama_pkg::sample_type            rsp_average,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kama_pkg::WINDOW_W-1:0]   csr_window_length
);
   import kama_pkg::*;

   localparam int PW  = $clog2(MAX_PERIOD + 2);
   localparam int SAW = $clog2(MAX_PERIOD + 1);
   localparam int DAW = $clog2(MAX_PERIOD);
   localparam int VW  = SAMPLE_W + $clog2(MAX_PERIOD);
   localparam int CW  = (PW > WINDOW_W) ? PW : WINDOW_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ_LAST,
      S_DIFF,
      S_UPDATE,
      S_DIVIDE,
      S_SSC,
      S_SQUARE,
      S_MULTIPLY,
      S_ACCUM,
      S_OUTPUT
   } state_type;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sample_type          rsp_average_ff, rsp_average_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [VW-1:0]       vol_ff, vol_in;
   logic [PW-1:0]       seen_ff, seen_in;
   logic [SAW-1:0]      wp_ff, wp_in;
   logic [DAW-1:0]      dp_ff, dp_in;
   avg_type             prev_ff, prev_in;
   sample_type          x_ff, x_in;
   logic [SAMPLE_W-1:0] d_ff, d_in;
   logic [SAMPLE_W-1:0] drop_ff, drop_in;
   coef_type            ssc_ff, ssc_in;
   diff_type            diff_ff, diff_in;

   logic [PW-1:0]       period;
   logic [CW-1:0]       window_wide;
   logic [SAW-1:0]      last_addr;
   logic [SAW-1:0]      wp_next;
   logic [DAW-1:0]      dp_next;
   logic                req_accept;
   logic                csr_write;

   logic                sram_wr_en;
   logic [SAW-1:0]      sram_rd_addr;
   sample_type          sram_rd_data;
   logic                dram_wr_en;
   logic [SAMPLE_W-1:0] dram_rd_data;

   logic                div_start;
   logic                div_done;
   ratio_type           div_quotient;
   logic                mul_start;
   logic                mul_done;
   prod_type            mul_product;

   logic [SAMPLE_W:0]   ssc_prod;
   logic [2*COEF_W-1:0] ssc_square;
   coef_type            coef;
   avg_type             x_wide;
   logic [AVG_W:0]      avg_round;

   // The window register is clamped to the range the rings can hold.
   always_comb begin
      window_wide = CW'(window_ff);
      if (window_ff == '0) begin
         period = PW'(1);
      end else if (window_wide > CW'(MAX_PERIOD)) begin
         period = PW'(MAX_PERIOD);
      end else begin
         period = PW'(window_wide);
      end
      last_addr = (wp_ff == '0) ? SAW'(period) : wp_ff - SAW'(1);
      wp_next   = (wp_ff == SAW'(period)) ? '0 : wp_ff + SAW'(1);
      dp_next   = (dp_ff == DAW'(period - PW'(1))) ? '0 : dp_ff + DAW'(1);
   end

   assign csr_ready  = (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE) || csr_valid;
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;

   assign sram_rd_addr = (state_ff == S_READ_LAST) ? last_addr : wp_next;
   assign sram_wr_en   = (state_ff == S_UPDATE);
   assign dram_wr_en   = (state_ff == S_UPDATE) && (seen_ff != '0);

   kama_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_PERIOD + 1)
   ) u_sample_ring (
      .clock   (clock),
      .wr_en   (sram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (x_ff),
      .rd_addr (sram_rd_addr),
      .rd_data (sram_rd_data)
   );

   kama_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_PERIOD)
   ) u_diff_ring (
      .clock   (clock),
      .wr_en   (dram_wr_en),
      .wr_addr (dp_ff),
      .wr_data (d_ff),
      .rd_addr (dp_ff),
      .rd_data (dram_rd_data)
   );

   kama_divider #(
      .VOL_W (VW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (abs_diff(x_ff, sram_rd_data)),
      .divisor  (vol_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   kama_multiplier u_multiplier (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (diff_ff),
      .coef         (coef),
      .done         (mul_done),
      .product      (mul_product)
   );

   always_comb begin
      ssc_prod   = (SAMPLE_W + 1)'(div_quotient) * (SAMPLE_W + 1)'(FAST_SLOW_Q16)
                   + (SAMPLE_W + 1)'(HALF_Q16);
      ssc_square = (2 * COEF_W)'(ssc_ff) * (2 * COEF_W)'(ssc_ff) + (2 * COEF_W)'(HALF_Q16);
      coef       = ssc_square[2*COEF_W-1 -: COEF_W];
      x_wide     = $signed({x_ff, {GUARD_W{1'b0}}});
      avg_round  = (AVG_W + 1)'(prev_ff) + (AVG_W + 1)'(HALF_Q16);
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      window_in      = window_ff;
      vol_in         = vol_ff;
      seen_in        = seen_ff;
      wp_in          = wp_ff;
      dp_in          = dp_ff;
      prev_in        = prev_ff;
      x_in           = x_ff;
      d_in           = d_ff;
      drop_in        = drop_ff;
      ssc_in         = ssc_ff;
      diff_in        = diff_ff;
      div_start      = 1'b0;
      mul_start      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (csr_write) begin
               window_in = csr_window_length;
               vol_in    = '0;
               seen_in   = '0;
               wp_in     = '0;
               dp_in     = '0;
            end else if (req_accept) begin
               x_in = req_sample;
               if (req_series_start) begin
                  vol_in  = '0;
                  seen_in = '0;
                  wp_in   = '0;
                  dp_in   = '0;
               end
               state_in = S_READ_LAST;
            end
         end
         S_READ_LAST: begin
            state_in = S_DIFF;
         end
         S_DIFF: begin
            d_in     = abs_diff(x_ff, sram_rd_data);
            drop_in  = (seen_ff > period) ? dram_rd_data : '0;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            // The sample ring read now returns the word leaving the window.
            if (seen_ff != '0) begin
               vol_in = vol_ff - VW'(drop_ff) + VW'(d_ff);
               dp_in  = dp_next;
            end
            wp_in = wp_next;
            if (seen_ff < period) begin
               seen_in  = seen_ff + PW'(1);
               state_in = S_IDLE;
            end else if (seen_ff == period) begin
               seen_in  = seen_ff + PW'(1);
               prev_in  = x_wide;
               state_in = S_OUTPUT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               state_in = S_SSC;
            end
         end
         S_SSC: begin
            ssc_in   = SLOW_Q16 + COEF_W'(ssc_prod >> GUARD_W);
            diff_in  = DIFF_W'(x_wide) - DIFF_W'(prev_ff);
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            mul_start = 1'b1;
            state_in  = S_MULTIPLY;
         end
         S_MULTIPLY: begin
            if (mul_done) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            prev_in  = prev_ff + AVG_W'(mul_product >>> GUARD_W);
            state_in = S_OUTPUT;
         end
         S_OUTPUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = avg_round[AVG_W-1 -: SAMPLE_W];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_RESET;
         vol_ff       <= '0;
         seen_ff      <= '0;
         wp_ff        <= '0;
         dp_ff        <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         vol_ff       <= vol_in;
         seen_ff      <= seen_in;
         wp_ff        <= wp_in;
         dp_ff        <= dp_in;
         prev_ff      <= prev_in;
      end
      rsp_average_ff <= rsp_average_in;
      x_ff           <= x_in;
      d_ff           <= d_in;
      drop_ff        <= drop_in;
      ssc_ff         <= ssc_in;
      diff_ff        <= diff_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

endmodule

[dv/kama_average_check.sv]
`timescale 1ns / 1ps
// Predicts every adaptive average word from the observed channels and compares it with the block.
module kama_average_check #(
   parameter int MAX_PERIOD = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  kama_pkg::sample_type            req_sample,
   input  logic                            req_series_start,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  kama_pkg::sample_type            rsp_average,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [kama_pkg::WINDOW_W-1:0]   csr_window_length,
   output int                              mismatch_count,
   output int                              pending_words,
   output int                              checked_words
);
   import kama_pkg::*;

   logic [WINDOW_W-1:0] window_reg;
   sample_type          price_ring [0:MAX_PERIOD];
   logic [31:0]         swing_ring [0:MAX_PERIOD-1];
   logic [63:0]         volatility;
   int unsigned         filled;
   int unsigned         price_head;
   int unsigned         swing_head;
   longint              running_avg;
   sample_type          average_queue [$];
   sample_type          expected_avg;

   task automatic clear_history();
      volatility = '0;
      filled     = 0;
      price_head = 0;
      swing_head = 0;
   endtask

   // Takes one sample word and queues the average word it produces, if any.
   task automatic advance_average(input sample_type x, input logic restart);
      int unsigned p;
      int unsigned last;
      longint      delta;
      longint      widened;
      longint      prod;
      logic [31:0] step_size;
      logic [31:0] trend;
      logic [63:0] ratio;
      logic [63:0] smooth;
      logic [63:0] coef;
      if (window_reg == 0) begin
         p = 1;
      end else if (window_reg > MAX_PERIOD) begin
         p = MAX_PERIOD;
      end else begin
         p = 32'(window_reg);
      end
      widened = longint'(x) * 65536;
      if (restart) begin
         clear_history();
      end
      if (filled > 0) begin
         last = (price_head + p) % (p + 1);
         delta = longint'(x) - longint'(price_ring[last]);
         step_size = 32'((delta < 0) ? -delta : delta);
         if (filled - 1 >= p) begin
            volatility -= 64'(swing_ring[swing_head]);
         end
         swing_ring[swing_head] = step_size;
         volatility += 64'(step_size);
         swing_head = (swing_head + 1) % p;
      end
      price_ring[price_head] = x;
      price_head = (price_head + 1) % (p + 1);
      if (filled < p) begin
         filled++;
         return;
      end
      if (filled == p) begin
         // The first full window seeds the average with the sample itself.
         filled++;
         running_avg = widened;
      end else begin
         delta = longint'(x) - longint'(price_ring[price_head]);
         trend = 32'((delta < 0) ? -delta : delta);
         ratio = '0;
         if (volatility != 0) begin
            ratio = {16'b0, trend, 16'b0} / volatility;
         end
         if (ratio > 64'd65536) begin
            ratio = 64'd65536;
         end
         smooth = 64'(SLOW_Q16) + ((ratio * 64'(FAST_SLOW_Q16) + 64'd32768) >> 16);
         coef = (smooth * smooth + 64'd32768) >> 16;
         prod = (widened - running_avg) * longint'(coef);
         running_avg += (prod + 64'sd32768) >>> 16;
      end
      average_queue.push_back(sample_type'((running_avg + 64'sd32768) >>> 16));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_reg = WINDOW_RESET;
         clear_history();
         running_avg = 0;
         average_queue.delete();
         mismatch_count = 0;
         checked_words = 0;
      end else begin
         // Results are compared before this edge's input is predicted: they belong to older words.
         if (rsp_valid && !rsp_stall) begin
            if (average_queue.size() == 0) begin
               mismatch_count++;
               $display("%0t: average word %h arrived with none expected", $time, rsp_average);
            end else begin
               expected_avg = average_queue.pop_front();
               checked_words++;
               if (expected_avg !== rsp_average) begin
                  mismatch_count++;
                  $display("%0t: average mismatch, expected %h, actual %h",
                           $time, expected_avg, rsp_average);
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_average(req_sample, req_series_start);
         end
         if (csr_valid && csr_ready) begin
            window_reg = csr_window_length;
            clear_history();
         end
      end
      pending_words = average_queue.size();
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the adaptive average testbench: clock, reset, sample and window stimulus, verdict.
module testbench;
   import kama_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   sample_type          req_sample = '0;
   logic                req_series_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   sample_type          rsp_average;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [WINDOW_W-1:0] csr_window_length = WINDOW_RESET;

   int         mismatch_count;
   int         pending_words;
   int         checked_words;
   int         send_idle = 0;
   int         recv_idle = 0;
   logic       hold_go = 1'b0;
   logic       hold_on = 1'b0;
   int         words_sent = 0;
   int         window_writes = 0;
   int         window_plan [10] = '{64, 127, 1, 7, 3, 33, 10, 2, 5, 20};
   sample_type price = 32'sh0064_0000;
   int         drift;
   int         word_total;

   kaufman_adaptive_average_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_series_start  (req_series_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   kama_average_check u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_series_start  (req_series_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length),
      .mismatch_count    (mismatch_count),
      .pending_words     (pending_words),
      .checked_words     (checked_words)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= hold_on || ($urandom_range(0, 99) < recv_idle);
   end

   // Holds the result side off long enough for the block to back up into its input.
   initial begin
      while (!hold_go) @(posedge clock);
      hold_on <= 1'b1;
      repeat (400) @(posedge clock);
      hold_on <= 1'b0;
   end

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle = sender_pct;
      recv_idle <= receiver_pct;
   endtask

   task automatic send_word(input sample_type value, input logic restart);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample       <= value;
      req_series_start <= restart;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // The window only changes once the block has drained; words before a full window
   // leave nothing behind, so some further cycles cover one still in progress.
   task automatic write_window(input logic [WINDOW_W-1:0] length);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_window_length <= length;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_writes++;
   endtask

   // Mostly a drifting price walk, with flat runs, rail values and full-range jumps.
   function automatic sample_type next_price(input sample_type cur, input int trend);
      int pick;
      int noise;
      pick = $urandom_range(0, 99);
      noise = int'($urandom_range(0, 131072)) - 65536;
      if (pick < 6) begin
         return sample_type'($urandom);
      end else if (pick < 14) begin
         return cur;
      end else if (pick < 17) begin
         return 32'sh7FFF_FFFF;
      end else if (pick < 20) begin
         return 32'sh8000_0000;
      end
      return sample_type'(cur + trend + noise);
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_idling(8, 76);

      // Reset window of ten, swinging between the rails.
      for (int i = 0; i < 12; i++) begin
         send_word(i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000, i == 0);
      end

      write_window(2);
      send_word(32'sh0000_0000, 1'b1);
      send_word(32'shFFFF_FFFF, 1'b0);
      send_word(32'sh0001_0000, 1'b0);
      send_word(32'sh0001_0000, 1'b0);
      send_word(32'sh0001_0000, 1'b0);
      send_word(32'sh0001_0000, 1'b0);
      // A new series begins again before the window has filled.
      send_word(32'sh0000_0005, 1'b1);
      send_word(32'sh0000_0006, 1'b0);
      send_word(32'sh0000_0007, 1'b1);
      send_word(32'sh0000_0008, 1'b0);
      send_word(32'sh0000_0009, 1'b0);

      // A zero window behaves as a window of one; flat prices give no volatility.
      write_window(0);
      repeat (4) send_word(32'sh4000_0000, 1'b0);

      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 3) begin
            set_idling(76, 8);
         end else if (ph == 6) begin
            set_idling(0, 0);
         end
         write_window(WINDOW_W'(window_plan[ph]));
         if (ph == 7) begin
            hold_go <= 1'b1;
         end
         drift = int'($urandom_range(0, 8192)) - 4096;
         word_total = (window_plan[ph] >= 64) ? 150 : 60;
         for (int k = 0; k < word_total; k++) begin
            price = next_price(price, drift);
            send_word(price, $urandom_range(0, 40 + 2 * window_plan[ph]) == 0);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d sample words under %0d window writes, zero and above the maximum included.",
               words_sent, window_writes);
      $display("Checked %0d average words with gaps and stalls on both sides and a long hold.",
               checked_words);
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
